// ===== design/label_image_rle_decoder_core_assert.svh =====
// Assertion macros shared by the decoder checker
`ifndef LABEL_IMAGE_RLE_DECODER_CORE_ASSERT_SVH
`define LABEL_IMAGE_RLE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, needs clk and rst in scope
`define LRD_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrd assertion failed");

// next-cycle implication, needs clk and rst in scope
`define LRD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrd assertion failed");

`endif

// ===== design/lrd_pkg.sv =====
// Types and constants of the label image run-length decoder
package lrd_pkg;

  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 16;
  localparam int SUM_W     = COUNT_W + 1;
  localparam int ALIGN_W   = 16;
  localparam int CAP_W     = 32;
  localparam int OFFSET_W  = 32;
  localparam int BYTES_W   = 32;
  localparam int ACC_W     = 34;
  localparam int PHASE_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_ALIGN       = 2'd0,
    REG_BUFFER_CAPACITY = 2'd1
  } cfg_reg_t;

  localparam logic [PHASE_W-1:0] PHASE_HEIGHT_HI = 4'd4;
  localparam logic [PHASE_W-1:0] PHASE_HEIGHT_LO = 4'd5;
  localparam logic [PHASE_W-1:0] PHASE_WIDTH_HI  = 4'd6;
  localparam logic [PHASE_W-1:0] PHASE_WIDTH_LO  = 4'd7;
  localparam logic [PHASE_W-1:0] PHASE_LABEL     = 4'd8;
  localparam logic [PHASE_W-1:0] PHASE_COUNT_LO  = 4'd9;
  localparam logic [PHASE_W-1:0] PHASE_COUNT_HI  = 4'd10;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FAILED    = 2'd1,
    STATUS_TOO_SMALL = 2'd2
  } status_t;

  typedef enum logic {
    KIND_RUN    = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
  } alu_req_t;

  // borrow: a < b on subtract, carry out on add
  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic             borrow;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR_CHECK,
    S_DIV,
    S_PAD,
    S_STRIDE,
    S_MUL,
    S_CAP,
    S_RUN_COL,
    S_RUN_COL_CHK,
    S_RUN_END,
    S_RUN_END_CHK,
    S_RUN_EMIT,
    S_ROW_PAD,
    S_ROW_PAD_CHK,
    S_STATUS
  } lrd_state_t;

endpackage

// ===== design/lrd_byte_if.sv =====
// Compressed byte stream channel
interface lrd_byte_if
  import lrd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  logic              final_byte;

  modport source (output valid, output stream_byte, output final_byte, input ready);
  modport sink   (input valid, input stream_byte, input final_byte, output ready);
endinterface

// ===== design/lrd_result_if.sv =====
// Run descriptor and status result channel
interface lrd_result_if
  import lrd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [OFFSET_W-1:0] write_offset;
  logic [COUNT_W-1:0]  run_length;
  logic [BYTE_W-1:0]   run_label;
  logic [1:0]          decode_status;
  logic [BYTES_W-1:0]  image_bytes;
  logic                last_result;

  modport source (
    output valid, output result_kind, output write_offset, output run_length,
    output run_label, output decode_status, output image_bytes, output last_result,
    input ready
  );
  modport sink (
    input valid, input result_kind, input write_offset, input run_length,
    input run_label, input decode_status, input image_bytes, input last_result,
    output ready
  );
endinterface

// ===== design/lrd_cfg_if.sv =====
// Configuration register write channel
interface lrd_cfg_if
  import lrd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/lrd_alu.sv =====
// Shared add/subtract unit with borrow flag
module lrd_alu
  import lrd_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ACC_W-1:0] operand_b;
  logic             carry_in;
  logic [ACC_W:0]   full_sum;

  always_comb begin
    unique case (req.op)
      ALU_ADD: begin
        operand_b = req.b;
        carry_in  = 1'b0;
      end
      ALU_SUB: begin
        operand_b = ~req.b;
        carry_in  = 1'b1;
      end
    endcase
  end

  assign full_sum   = {1'b0, req.a} + {1'b0, operand_b} + {{ACC_W{1'b0}}, carry_in};
  assign rsp.sum    = full_sum[ACC_W-1:0];
  assign rsp.borrow = (req.op == ALU_SUB) ? !full_sum[ACC_W] : full_sum[ACC_W];

endmodule

// ===== design/lrd_seq.sv =====
// Byte parser, header and run sequencer, result register
module lrd_seq
  import lrd_pkg::*;
#(
  parameter int DIMENSION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [ALIGN_W-1:0] row_align,
  input  logic [CAP_W-1:0]   buffer_capacity,
  lrd_byte_if.sink           stream,
  lrd_result_if.source       result,
  output alu_req_t           alu_req,
  input  alu_rsp_t           alu_rsp
);

  localparam int IterW = $clog2(DIMENSION_BITS);

  lrd_state_t state, state_next;

  logic [PHASE_W-1:0]        phase;
  status_t                   err;
  logic                      fin_held;
  logic [BYTE_W-1:0]         hdr_hi;
  logic [DIMENSION_BITS-1:0] height;
  logic [DIMENSION_BITS-1:0] width;
  logic [ALIGN_W-1:0]        padding;
  logic [ALIGN_W-1:0]        rem;
  logic [DIMENSION_BITS-1:0] div_shift;
  logic [DIMENSION_BITS-1:0] mul_shift;
  logic [ACC_W-1:0]          mcand;
  logic [ACC_W-1:0]          total;
  logic [IterW-1:0]          iter;
  logic [DIMENSION_BITS-1:0] column;
  logic [ACC_W-1:0]          offset;
  logic [ACC_W-1:0]          end_off;
  logic [SUM_W-1:0]          col_sum;
  logic                      col_full;
  logic [BYTE_W-1:0]         label;
  logic [BYTE_W-1:0]         count_low;
  logic [COUNT_W-1:0]        run_len;

  logic                out_valid;
  logic                out_kind;
  logic [OFFSET_W-1:0] out_offset;
  logic [COUNT_W-1:0]  out_length;
  logic [BYTE_W-1:0]   out_label;
  logic [1:0]          out_status;
  logic [BYTES_W-1:0]  out_bytes;
  logic                out_last;

  logic       out_free;
  logic       out_load;
  logic       accept;
  lrd_state_t done_state;
  status_t    err_final;

  assign stream.ready = (state == S_IDLE);
  assign accept       = stream.valid && (state == S_IDLE);
  assign out_free     = !out_valid || result.ready;
  // a new beat enters the output register
  assign out_load     = out_free && (state == S_RUN_EMIT || state == S_STATUS);
  assign done_state   = fin_held ? S_STATUS : S_IDLE;
  // a stream that ends inside the header fails
  assign err_final    = (err == STATUS_OK && phase < PHASE_LABEL) ? STATUS_FAILED : err;

  assign result.valid         = out_valid;
  assign result.result_kind   = out_kind;
  assign result.write_offset  = out_offset;
  assign result.run_length    = out_length;
  assign result.run_label     = out_label;
  assign result.decode_status = out_status;
  assign result.image_bytes   = out_bytes;
  assign result.last_result   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_req    = '{op: ALU_ADD, a: '0, b: '0};
    unique case (state)
      S_IDLE: begin
        if (stream.valid) begin
          if (err == STATUS_OK && phase == PHASE_WIDTH_LO) begin
            state_next = S_HDR_CHECK;
          end else if (err == STATUS_OK && phase == PHASE_COUNT_HI) begin
            state_next = S_RUN_COL;
          end else if (stream.final_byte) begin
            state_next = S_STATUS;
          end
        end
      end
      S_HDR_CHECK: begin
        if (height == '0 || width == '0) begin
          state_next = done_state;
        end else if (row_align == '0) begin
          state_next = S_STRIDE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        // restoring remainder step: width mod row_align
        alu_req = '{op: ALU_SUB, a: ACC_W'({rem, div_shift[DIMENSION_BITS-1]}),
                    b: ACC_W'(row_align)};
        if (iter == '0) state_next = S_PAD;
      end
      S_PAD: begin
        alu_req    = '{op: ALU_SUB, a: ACC_W'(row_align), b: ACC_W'(rem)};
        state_next = S_STRIDE;
      end
      S_STRIDE: begin
        alu_req    = '{op: ALU_ADD, a: ACC_W'(width), b: ACC_W'(padding)};
        state_next = S_MUL;
      end
      S_MUL: begin
        // shift-add: total += stride << i for each set height bit
        alu_req = '{op: ALU_ADD, a: total, b: mcand};
        if (iter == '0) state_next = S_CAP;
      end
      S_CAP: begin
        alu_req    = '{op: ALU_SUB, a: ACC_W'(buffer_capacity), b: total};
        state_next = done_state;
      end
      S_RUN_COL: begin
        alu_req    = '{op: ALU_ADD, a: ACC_W'(column), b: ACC_W'(run_len)};
        state_next = S_RUN_COL_CHK;
      end
      S_RUN_COL_CHK: begin
        alu_req    = '{op: ALU_SUB, a: ACC_W'(width), b: ACC_W'(col_sum)};
        state_next = alu_rsp.borrow ? done_state : S_RUN_END;
      end
      S_RUN_END: begin
        alu_req    = '{op: ALU_ADD, a: offset, b: ACC_W'(run_len)};
        state_next = S_RUN_END_CHK;
      end
      S_RUN_END_CHK: begin
        alu_req    = '{op: ALU_SUB, a: total, b: end_off};
        state_next = alu_rsp.borrow ? done_state : S_RUN_EMIT;
      end
      S_RUN_EMIT: begin
        if (out_free) state_next = col_full ? S_ROW_PAD : done_state;
      end
      S_ROW_PAD: begin
        alu_req    = '{op: ALU_ADD, a: offset, b: ACC_W'(padding)};
        state_next = S_ROW_PAD_CHK;
      end
      S_ROW_PAD_CHK: begin
        alu_req    = '{op: ALU_SUB, a: total, b: offset};
        state_next = done_state;
      end
      S_STATUS: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      err       <= STATUS_OK;
      fin_held  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fin_held <= stream.final_byte;
            if (err == STATUS_OK) begin
              unique case (phase) inside
                PHASE_HEIGHT_HI, PHASE_WIDTH_HI: hdr_hi <= stream.stream_byte;
                PHASE_HEIGHT_LO: height <= DIMENSION_BITS'({hdr_hi, stream.stream_byte});
                PHASE_WIDTH_LO:  width <= DIMENSION_BITS'({hdr_hi, stream.stream_byte});
                PHASE_LABEL:     label <= stream.stream_byte;
                PHASE_COUNT_LO:  count_low <= stream.stream_byte;
                PHASE_COUNT_HI:  run_len <= {stream.stream_byte, count_low};
                default: ;
              endcase
              phase <= (phase == PHASE_COUNT_HI) ? PHASE_LABEL : phase + PHASE_W'(1);
            end
          end
        end
        S_HDR_CHECK: begin
          if (height == '0 || width == '0) err <= STATUS_FAILED;
          padding   <= '0;
          rem       <= '0;
          div_shift <= width;
          iter      <= IterW'(DIMENSION_BITS - 1);
        end
        S_DIV: begin
          rem       <= alu_rsp.borrow ? {rem[ALIGN_W-2:0], div_shift[DIMENSION_BITS-1]}
                                      : alu_rsp.sum[ALIGN_W-1:0];
          div_shift <= div_shift << 1;
          iter      <= iter - IterW'(1);
        end
        S_PAD: begin
          padding <= (rem == '0) ? '0 : alu_rsp.sum[ALIGN_W-1:0];
        end
        S_STRIDE: begin
          mcand     <= alu_rsp.sum;
          total     <= '0;
          mul_shift <= height;
          iter      <= IterW'(DIMENSION_BITS - 1);
        end
        S_MUL: begin
          if (mul_shift[0]) total <= alu_rsp.sum;
          mcand     <= mcand << 1;
          mul_shift <= mul_shift >> 1;
          iter      <= iter - IterW'(1);
        end
        S_CAP: begin
          if (alu_rsp.borrow) err <= STATUS_TOO_SMALL;
          column <= '0;
          offset <= '0;
        end
        S_RUN_COL: begin
          col_sum <= alu_rsp.sum[SUM_W-1:0];
        end
        S_RUN_COL_CHK: begin
          if (alu_rsp.borrow) err <= STATUS_FAILED;
          col_full <= (alu_rsp.sum == '0);
        end
        S_RUN_END: begin
          end_off <= alu_rsp.sum;
        end
        S_RUN_END_CHK: begin
          if (alu_rsp.borrow) err <= STATUS_FAILED;
        end
        S_RUN_EMIT: begin
          if (out_free) begin
            out_kind   <= KIND_RUN;
            out_offset <= offset[OFFSET_W-1:0];
            out_length <= run_len;
            out_label  <= label;
            out_status <= STATUS_OK;
            out_bytes  <= '0;
            out_last   <= 1'b0;
            offset     <= end_off;
            column     <= col_full ? '0 : col_sum[DIMENSION_BITS-1:0];
          end
        end
        S_ROW_PAD: begin
          offset <= alu_rsp.sum;
        end
        S_ROW_PAD_CHK: begin
          if (alu_rsp.borrow) err <= STATUS_FAILED;
        end
        S_STATUS: begin
          if (out_free) begin
            out_kind   <= KIND_STATUS;
            out_offset <= '0;
            out_length <= '0;
            out_label  <= '0;
            out_status <= err_final;
            out_bytes  <= (err_final == STATUS_OK) ? total[BYTES_W-1:0] : '0;
            out_last   <= 1'b1;
            phase      <= '0;
            err        <= STATUS_OK;
            fin_held   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/label_image_rle_decoder_core.sv =====
// Top level of the label image run-length decoder
//
// Channel  Role    Beat contents
// cfg      sink    index, data (0 row_align, 1 buffer_capacity)
// stream   sink    stream_byte, final_byte
// result   source  result_kind, write_offset, run_length, run_label,
//                  decode_status, image_bytes, last_result
//
// Magic, height, label and count-low bytes need no adder step.
// Count-high byte: column sum and width check, end offset and image size check,
// then the emit step; a run that closes a row adds row padding and its check. Every
// step but the emit is one pass through the shared adder (sum, then compare).
// Last header byte: header check, then on that adder the bit-serial remainder
// and padding (skipped with row_align 0), stride, shift-add multiply and capacity check.
// The final byte adds a status beat. Result beats wait in the output register;
// only the emit steps stall on result.ready. Reset is synchronous; cfg is always ready.
module label_image_rle_decoder_core
  import lrd_pkg::*;
#(
  parameter int DIMENSION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  lrd_cfg_if.sink      cfg,
  lrd_byte_if.sink     stream,
  lrd_result_if.source result
);

  logic [ALIGN_W-1:0] row_align;
  logic [CAP_W-1:0]   buffer_capacity;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_align       <= '0;
      buffer_capacity <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROW_ALIGN:       row_align <= cfg.data[ALIGN_W-1:0];
        REG_BUFFER_CAPACITY: buffer_capacity <= cfg.data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  lrd_seq #(
    .DIMENSION_BITS(DIMENSION_BITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .row_align      (row_align),
    .buffer_capacity(buffer_capacity),
    .stream         (stream),
    .result         (result),
    .alu_req        (alu_req),
    .alu_rsp        (alu_rsp)
  );

  lrd_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

endmodule

// ===== design/lrd_checker.sv =====
// Port-level checks of the decoder, bound to the top level
`include "label_image_rle_decoder_core_assert.svh"

module lrd_checker
  import lrd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                stream_valid,
  input logic                stream_ready,
  input logic                stream_final,
  input logic                result_valid,
  input logic                result_ready,
  input logic                result_kind,
  input logic [OFFSET_W-1:0] write_offset,
  input logic [COUNT_W-1:0]  run_length,
  input logic [1:0]          decode_status,
  input logic [BYTES_W-1:0]  image_bytes,
  input logic                last_result
);

  // a stalled beat keeps its contents
  `LRD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(write_offset) && $stable(run_length) && $stable(result_kind))

  // the last byte always leads to a status beat, so the block goes busy
  `LRD_ASSERT_NEXT(a_final_busy, stream_valid && stream_ready && stream_final, !stream_ready)

  `LRD_ASSERT_SAME(a_status_beat, result_valid && result_kind == KIND_STATUS, last_result && run_length == '0 && (decode_status == STATUS_OK || image_bytes == '0))

  `LRD_ASSERT_SAME(a_run_beat, result_valid && result_kind == KIND_RUN, !last_result && decode_status == STATUS_OK && image_bytes == '0)

endmodule

bind label_image_rle_decoder_core lrd_checker u_lrd_checker (
  .clk          (clk),
  .rst          (rst),
  .stream_valid (stream.valid),
  .stream_ready (stream.ready),
  .stream_final (stream.final_byte),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_kind  (result.result_kind),
  .write_offset (result.write_offset),
  .run_length   (result.run_length),
  .decode_status(result.decode_status),
  .image_bytes  (result.image_bytes),
  .last_result  (result.last_result)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the label image run-length decoder core
module tb_top;
  import lrd_pkg::*;

  localparam int DRAIN_CYCLES = 60;   // covers the header divide/multiply pass
  localparam int LONG_HOLD    = 300;
  localparam int WATCHDOG     = 3000;
  localparam int BYTE_TARGET  = 800;

  typedef struct {
    kind_t       result_kind;
    logic [31:0] write_offset;
    logic [15:0] run_length;
    logic [7:0]  run_label;
    status_t     decode_status;
    logic [31:0] image_bytes;
    logic        last_result;
  } result_t;

  // Tracks the decoder state byte by byte and holds the results still due.
  class image_decode_tracker;
    logic [15:0]     row_align;
    logic [31:0]     capacity;
    logic [3:0]      phase;
    logic [15:0]     height, width, padding;
    logic [16:0]     col, row;
    longint unsigned offset;
    logic [7:0]      label, count_lo;
    status_t         err;
    result_t         due_results[$];
    int              mismatches;
    int              used_bytes;

    function new();
      row_align = '0;
      capacity = '0;
      mismatches = 0;
      used_bytes = 0;
      clear_image();
    endfunction

    function void clear_image();
      phase = '0;
      height = '0;
      width = '0;
      padding = '0;
      col = '0;
      row = '0;
      offset = 0;
      label = '0;
      count_lo = '0;
      err = STATUS_OK;
    endfunction

    function longint unsigned image_total();
      longint unsigned h, s;
      h = height;
      s = width;
      s += padding;
      return h * s;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        REG_ROW_ALIGN:       row_align = d[15:0];
        REG_BUFFER_CAPACITY: capacity = d;
        default: ;
      endcase
    endfunction

    function void finish_header();
      longint unsigned stride;
      if (height == 0 || width == 0) begin
        err = STATUS_FAILED;
        return;
      end
      stride = width;
      if (row_align != 0) stride = (stride + row_align - 1) / row_align * row_align;
      padding = 16'(stride - width);
      col = '0;
      row = '0;
      offset = 0;
      if (image_total() > capacity) err = STATUS_TOO_SMALL;
    endfunction

    function void close_run(logic [15:0] cnt);
      longint unsigned new_col, new_end, lim;
      result_t r;
      new_col = col;
      new_col += cnt;
      new_end = offset + cnt;
      lim = image_total();
      // failing run is dropped, not emitted
      if (new_col > width || new_end > lim) begin
        err = STATUS_FAILED;
        return;
      end
      r.result_kind = KIND_RUN;
      r.write_offset = 32'(offset);
      r.run_length = cnt;
      r.run_label = label;
      r.decode_status = STATUS_OK;
      r.image_bytes = '0;
      r.last_result = 1'b0;
      due_results.push_back(r);
      offset = new_end;
      col = 17'(new_col);
      if (col == width) begin
        row = row + 1'b1;
        col = '0;
        offset += padding;
        if (offset > lim) err = STATUS_FAILED;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      result_t r;
      used_bytes++;
      if (err == STATUS_OK) begin
        if (phase < PHASE_LABEL) begin
          case (phase)
            PHASE_HEIGHT_HI: height = {b, 8'h00};
            PHASE_HEIGHT_LO: height[7:0] = b;
            PHASE_WIDTH_HI:  width = {b, 8'h00};
            PHASE_WIDTH_LO: begin
              width[7:0] = b;
              finish_header();
            end
            default: ;
          endcase
          phase = phase + 1'b1;
        end else if (phase == PHASE_LABEL) begin
          label = b;
          phase = PHASE_COUNT_LO;
        end else if (phase == PHASE_COUNT_LO) begin
          count_lo = b;
          phase = PHASE_COUNT_HI;
        end else begin
          close_run({b, count_lo});
          phase = PHASE_LABEL;
        end
      end
      if (fin) begin
        // stream ended inside the header
        if (err == STATUS_OK && phase < PHASE_LABEL) err = STATUS_FAILED;
        r.result_kind = KIND_STATUS;
        r.write_offset = '0;
        r.run_length = '0;
        r.run_label = '0;
        r.decode_status = err;
        r.image_bytes = (err == STATUS_OK) ? 32'(image_total()) : 32'd0;
        r.last_result = 1'b1;
        due_results.push_back(r);
        clear_image();
      end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare("result_kind", want.result_kind, got.result_kind);
      compare("write_offset", want.write_offset, got.write_offset);
      compare("run_length", want.run_length, got.run_length);
      compare("run_label", want.run_label, got.run_label);
      compare("decode_status", want.decode_status, got.decode_status);
      compare("image_bytes", want.image_bytes, got.image_bytes);
      compare("last_result", want.last_result, got.last_result);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  lrd_cfg_if    cfg_if();
  lrd_byte_if   byte_if();
  lrd_result_if res_if();

  label_image_rle_decoder_core #(.DIMENSION_BITS(16)) uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .stream (byte_if),
    .result (res_if)
  );

  image_decode_tracker tracker;
  logic [7:0] image_stream[$];
  bit         send_gap_max;
  bit         recv_gap_max;
  bit         hold_request;
  int         idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: predictor update, result check, watchdog
  always @(posedge clk) begin
    result_t got;
    bit moved;
    moved = 1'b0;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        tracker.set_reg(cfg_reg_t'(cfg_if.index), cfg_if.data);
        moved = 1'b1;
      end
      if (byte_if.valid && byte_if.ready) begin
        tracker.note_byte(byte_if.stream_byte, byte_if.final_byte);
        moved = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        got.result_kind = kind_t'(res_if.result_kind);
        got.write_offset = res_if.write_offset;
        got.run_length = res_if.run_length;
        got.run_label = res_if.run_label;
        got.decode_status = status_t'(res_if.decode_status);
        got.image_bytes = res_if.image_bytes;
        got.last_result = res_if.last_result;
        tracker.check_result(got);
        moved = 1'b1;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result sink: random hold-off per beat, one long hold on request
  initial begin
    int stall;
    res_if.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        stall = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        stall = recv_gap_max ? $urandom_range(0, 7) : 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = send_gap_max ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_if.valid <= 1'b1;
    byte_if.stream_byte <= b;
    byte_if.final_byte <= fin;
    do @(posedge clk); while (!byte_if.ready);
    @(negedge clk);
  endtask

  task automatic send_image();
    foreach (image_stream[i]) send_byte(image_stream[i], i == image_stream.size() - 1);
  endtask

  task automatic program_regs(input logic [15:0] align, input logic [31:0] cap);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_ROW_ALIGN;
    cfg_if.data <= {16'h0000, align};
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.index <= REG_BUFFER_CAPACITY;
    cfg_if.data <= cap;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // wait for every due result, then let the core go fully quiet
  task automatic drain();
    byte_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void add_run(logic [7:0] lab, logic [15:0] cnt);
    image_stream.push_back(lab);
    image_stream.push_back(cnt[7:0]);
    image_stream.push_back(cnt[15:8]);
  endfunction

  function automatic void add_header(logic [15:0] h, logic [15:0] w);
    repeat (4) image_stream.push_back(8'($urandom));
    image_stream.push_back(h[15:8]);
    image_stream.push_back(h[7:0]);
    image_stream.push_back(w[15:8]);
    image_stream.push_back(w[7:0]);
  endfunction

  // complete rows, with zero-length runs mixed in
  function automatic void add_rows(int rows, int w);
    int left;
    int cnt;
    for (int r = 0; r < rows; r++) begin
      left = w;
      while (left > 0) begin
        cnt = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, left);
        add_run(8'($urandom), 16'(cnt));
        left -= cnt;
      end
    end
  endfunction

  function automatic void build_image();
    int pick, h, w, rows;
    image_stream.delete();
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      h = $urandom_range(1, 4);
      w = $urandom_range(1, 24);
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) != 0) h = 0;
        else w = 0;
      end
      add_header(16'(h), 16'(w));
      rows = ($urandom_range(0, 3) == 0) ? $urandom_range(0, h) : h;
      add_rows(rows, w);
      if (rows < h && $urandom_range(0, 1) != 0)
        add_run(8'($urandom), 16'($urandom_range(0, w)));
      // trailing partial triplet
      if ($urandom_range(0, 6) == 0)
        repeat ($urandom_range(1, 2)) image_stream.push_back(8'($urandom));
    end else if (pick < 14) begin
      h = ($urandom_range(0, 1) != 0) ? 16'hFFFF : $urandom_range(1, 16'hFFFF);
      w = ($urandom_range(0, 1) != 0) ? 16'hFFFF : $urandom_range(1, 16'hFFFF);
      add_header(16'(h), 16'(w));
      repeat ($urandom_range(0, 2)) add_run(8'($urandom), 16'($urandom_range(0, w)));
    end else if (pick < 17) begin
      h = $urandom_range(1, 4);
      w = $urandom_range(1, 24);
      add_header(16'(h), 16'(w));
      if ($urandom_range(0, 1) != 0) begin
        // one run beyond the last row
        add_rows(h, w);
        add_run(8'($urandom), 16'($urandom_range(1, 16'hFFFF)));
      end else begin
        add_rows($urandom_range(0, h - 1), w);
        add_run(8'($urandom), 16'($urandom_range(w + 1, 16'hFFFF)));
      end
      repeat ($urandom_range(0, 3)) add_run(8'($urandom), 16'($urandom));
    end else begin
      repeat ($urandom_range(1, 20)) image_stream.push_back(8'($urandom));
    end
  endfunction

  initial begin
    int phase_no;
    logic [15:0] align;
    logic [31:0] cap;
    tracker = new();
    rst = 1'b1;
    byte_if.valid = 1'b0;
    byte_if.stream_byte = '0;
    byte_if.final_byte = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_ROW_ALIGN;
    cfg_if.data = '0;
    send_gap_max = 1'b0;
    recv_gap_max = 1'b0;
    hold_request = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    program_regs(16'd0, 32'hFFFF_FFFF);
    // zero-count run, then a run on the final byte
    image_stream = '{8'hFF, 8'h00, 8'h5A, 8'hA5, 8'h00, 8'h01, 8'h00, 8'h02,
                     8'hFF, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00};
    send_image();
    // stream ends inside the header
    image_stream = '{8'h5A, 8'hFF};
    send_image();
    // zero height with maximum width
    image_stream = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
    send_image();
    drain();

    phase_no = 0;
    while (tracker.used_bytes < BYTE_TARGET) begin
      case ($urandom_range(0, 3))
        0: align = 16'd0;
        1: align = 16'd1;
        2: align = 16'hFFFF;
        default: align = 16'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 5))
        0: cap = 32'd0;
        1: cap = $urandom_range(0, 400);
        default: cap = 32'hFFFF_FFFF;
      endcase
      program_regs(align, cap);
      send_gap_max = ($urandom_range(0, 2) != 0);
      recv_gap_max = ($urandom_range(0, 2) != 0);
      // first phase: sink holds off while bytes keep coming
      if (phase_no == 0) begin
        hold_request = 1'b1;
        send_gap_max = 1'b0;
      end
      repeat ($urandom_range(3, 8)) begin
        build_image();
        send_image();
      end
      drain();
      phase_no++;
    end

    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/lrd_pkg.sv
design/lrd_byte_if.sv
design/lrd_result_if.sv
design/lrd_cfg_if.sv
design/lrd_alu.sv
design/lrd_seq.sv
design/label_image_rle_decoder_core.sv
design/lrd_checker.sv
tb/tb_top.sv
